/* src/fsfd_pkg.sv */
// ----------------------------------------------------------------------------
// Flow sensor frame decoder package
// Shared widths, register indexes and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package fsfd_pkg;

  localparam int BYTE_W     = 8;
  localparam int RAW_W      = 16;
  localparam int DIVISOR_W  = 16;
  localparam int DIVIDEND_W = 24;
  localparam int FLOW_W     = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAME_BYTES = 3;

  localparam logic [RAW_W-1:0]  OFFSET_RST = 16'd32000;
  localparam logic [RAW_W-1:0]  SCALE_RST  = 16'd140;
  localparam logic [BYTE_W-1:0] POLY_RST   = 8'h31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOW_OFFSET = 2'd0,
    REG_FLOW_SCALE  = 2'd1,
    REG_CRC_POLY    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_sts_t;

  // One CRC-8 byte: xor in the byte, then eight MSB-first shifts.
  function automatic logic [BYTE_W-1:0] crc8_byte(
    input logic [BYTE_W-1:0] crc_in,
    input logic [BYTE_W-1:0] data,
    input logic [BYTE_W-1:0] poly
  );
    logic [BYTE_W-1:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/fsfd_divider.sv */
// ----------------------------------------------------------------------------
// Flow sensor frame decoder divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsfd_divider
  import fsfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_sts_t sts
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [DIVISOR_W:0]    trial;
  logic                  qbit;

  // Bring down the next dividend bit and try the subtract.
  assign trial   = {rem_r, quo_r[DIVIDEND_W-1]} - {1'b0, dvs_r};
  assign qbit    = ~trial[DIVISOR_W];
  assign rem_nxt = qbit ? trial[DIVISOR_W-1:0] : {rem_r[DIVISOR_W-2:0], quo_r[DIVIDEND_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
        cnt_r  <= CNT_W'(DIVIDEND_W - 1);
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIVIDEND_W-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy     = busy_r;
  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule

/* src/flow_sensor_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// Flow sensor frame decoder
// CRC-8 frame check, sticky error flag and Q.8 flow conversion.
// ----------------------------------------------------------------------------
// One frame is taken at a time. A frame with a failed read skips the CRC and
// goes straight to the result; a good read runs the CRC over its three bytes,
// one byte per cycle, and a frame that passes CRC then goes through the
// restoring divider, one quotient bit per cycle. The result sits in an output
// register, so a new frame is taken while it waits.
// Configuration writes are taken every cycle and must come while idle.
module flow_sensor_frame_decoder_unit
  import fsfd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [BYTE_W-1:0]        in_flow_high_byte,
  input  logic [BYTE_W-1:0]        in_flow_low_byte,
  input  logic [BYTE_W-1:0]        in_crc_byte,
  input  logic                     in_read_failed,
  input  logic                     in_resend_failed,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [FLOW_W-1:0] out_flow_value,
  output logic                     out_sample_updated,
  output logic                     out_crc_mismatch,
  output logic                     out_sensor_error
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

  state_t                   state_r;
  logic [RAW_W-1:0]         offset_r;
  logic [RAW_W-1:0]         scale_r;
  logic [BYTE_W-1:0]        poly_r;
  logic [BYTE_W-1:0]        hi_r;
  logic [BYTE_W-1:0]        lo_r;
  logic [BYTE_W-1:0]        cb_r;
  logic                     rd_fail_r;
  logic                     rs_fail_r;
  logic [1:0]               idx_r;
  logic [BYTE_W-1:0]        crc_r;
  logic [BYTE_W-1:0]        crc_nxt;
  logic [BYTE_W-1:0]        cur_byte;
  logic                     neg_r;
  logic                     upd_r;
  logic                     mis_r;
  logic signed [FLOW_W-1:0] held_flow_r;
  logic                     error_r;
  logic                     out_valid_r;
  logic signed [FLOW_W-1:0] out_flow_r;
  logic                     out_upd_r;
  logic                     out_mis_r;
  logic                     out_err_r;
  logic [RAW_W:0]           diff;
  logic [RAW_W-1:0]         diff_mag;
  logic [FLOW_W-1:0]        quo_ext;
  logic                     error_nxt;
  div_req_t                 div_req;
  div_sts_t                 div_sts;

  always_comb begin
    case (idx_r)
      2'd0:    cur_byte = hi_r;
      2'd1:    cur_byte = lo_r;
      default: cur_byte = cb_r;
    endcase
  end

  assign crc_nxt  = crc8_byte(crc_r, cur_byte, poly_r);
  assign diff     = {1'b0, hi_r, lo_r} - {1'b0, offset_r};
  assign diff_mag = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
  assign quo_ext  = {1'b0, div_sts.quotient};

  assign div_req.start    = (state_r == S_CHECK) && (crc_r == '0);
  assign div_req.dividend = {diff_mag, {BYTE_W{1'b0}}};
  assign div_req.divisor  = (scale_r == '0) ? DIVISOR_W'(1) : scale_r;

  assign error_nxt = rd_fail_r ? (error_r | rs_fail_r) : 1'b0;

  fsfd_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      scale_r  <= SCALE_RST;
      poly_r   <= POLY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FLOW_OFFSET: offset_r <= cfg_data;
        REG_FLOW_SCALE:  scale_r  <= cfg_data;
        REG_CRC_POLY:    poly_r   <= cfg_data[BYTE_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_flow_r <= '0;
      error_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself.
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            hi_r      <= in_flow_high_byte;
            lo_r      <= in_flow_low_byte;
            cb_r      <= in_crc_byte;
            rd_fail_r <= in_read_failed;
            rs_fail_r <= in_resend_failed;
            idx_r     <= '0;
            crc_r     <= '0;
            upd_r     <= 1'b0;
            mis_r     <= 1'b0;
            state_r   <= in_read_failed ? S_DONE : S_CRC;
          end
        end
        S_CRC: begin
          crc_r <= crc_nxt;
          idx_r <= idx_r + 1'b1;
          if (idx_r == 2'(FRAME_BYTES - 1)) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          neg_r <= diff[RAW_W];
          if (crc_r == '0) begin
            state_r <= S_DIV;
          end else begin
            mis_r   <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            held_flow_r <= neg_r ? -quo_ext : quo_ext;
            upd_r       <= 1'b1;
            state_r     <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_flow_r  <= held_flow_r;
            out_upd_r   <= upd_r;
            out_mis_r   <= mis_r;
            out_err_r   <= error_nxt;
            error_r     <= error_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready          = 1'b1;
  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_flow_value     = out_flow_r;
  assign out_sample_updated = out_upd_r;
  assign out_crc_mismatch   = out_mis_r;
  assign out_sensor_error   = out_err_r;

  a_upd_mis_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_sample_updated && out_crc_mismatch))
    else $error("sample_updated and crc_mismatch both set");

  a_mismatch_clears_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_crc_mismatch) |-> !out_sensor_error)
    else $error("crc mismatch reported with sensor error set");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> (state_r == S_DIV))
    else $error("divider busy outside the divide state");

  a_flow_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !upd_r) |=> $stable(held_flow_r))
    else $error("held flow changed on a frame that did not update");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flow sensor frame decoder testbench
// Drives sensor frames with random bursts and gaps, stalls the result side on
// changing patterns, and checks every result against a local predictor of the
// CRC-8 frame check, the sticky error flag and the Q.8 flow conversion.
// Register settings change between phases while the decoder is idle.
// ----------------------------------------------------------------------------
module testbench;
  import fsfd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic [BYTE_W-1:0] flow_hi;
    logic [BYTE_W-1:0] flow_lo;
    logic [BYTE_W-1:0] crc;
    logic              rd_fail;
    logic              rs_fail;
  } frame_t;

  typedef struct {
    logic signed [FLOW_W-1:0] flow;
    logic                     updated;
    logic                     mismatch;
    logic                     error;
  } reading_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index = REG_FLOW_OFFSET;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_flow_high_byte = '0;
  logic [BYTE_W-1:0] in_flow_low_byte = '0;
  logic [BYTE_W-1:0] in_crc_byte = '0;
  logic              in_read_failed = 1'b0;
  logic              in_resend_failed = 1'b0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [FLOW_W-1:0] out_flow_value;
  logic                     out_sample_updated;
  logic                     out_crc_mismatch;
  logic                     out_sensor_error;

  // Predictor state and register copies
  logic [RAW_W-1:0]     offset_cfg = OFFSET_RST;
  logic [DIVISOR_W-1:0] scale_cfg = SCALE_RST;
  logic [BYTE_W-1:0]    poly_cfg = POLY_RST;
  int                   held_flow = 0;
  logic                 error_flag = 1'b0;

  frame_t   pending_frames[$];
  reading_t expected_readings[$];
  int       frames_queued = 0;
  int       frames_taken = 0;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  logic        in_acc = 1'b0;
  frame_t      send_frame;
  int          burst_left = 0;
  int          idle_left = 0;
  rx_pattern_t rx_pattern = RX_STEADY;
  int          rx_left = 0;
  reading_t    want;

  flow_sensor_frame_decoder_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_flow_high_byte  (in_flow_high_byte),
    .in_flow_low_byte   (in_flow_low_byte),
    .in_crc_byte        (in_crc_byte),
    .in_read_failed     (in_read_failed),
    .in_resend_failed   (in_resend_failed),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_flow_value     (out_flow_value),
    .out_sample_updated (out_sample_updated),
    .out_crc_mismatch   (out_crc_mismatch),
    .out_sensor_error   (out_sensor_error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bitwise CRC-8, MSB first, over the low nbits of msg, starting from zero.
  function automatic logic [BYTE_W-1:0] crc8_msb(logic [23:0] msg, int nbits,
                                                 logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] c;
    logic              fb;
    c = '0;
    for (int i = nbits - 1; i >= 0; i--) begin
      fb = c[BYTE_W-1] ^ msg[i];
      c = {c[BYTE_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] check_byte(logic [RAW_W-1:0] raw);
    return crc8_msb({8'h00, raw}, 16, poly_cfg);
  endfunction

  function automatic reading_t predict_reading(frame_t f);
    reading_t r;
    int       diff;
    int       divisor;
    r.updated = 1'b0;
    r.mismatch = 1'b0;
    if (f.rd_fail) begin
      if (f.rs_fail) begin
        error_flag = 1'b1;
      end
    end else begin
      error_flag = 1'b0;
      if (crc8_msb({f.flow_hi, f.flow_lo, f.crc}, 24, poly_cfg) == '0) begin
        diff = int'({f.flow_hi, f.flow_lo}) - int'(offset_cfg);
        // zero scale divides by one
        divisor = (scale_cfg == '0) ? 1 : int'(scale_cfg);
        held_flow = (diff * 256) / divisor;
        r.updated = 1'b1;
      end else begin
        r.mismatch = 1'b1;
      end
    end
    r.flow = held_flow[FLOW_W-1:0];
    r.error = error_flag;
    return r;
  endfunction

  task automatic queue_frame(logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo,
                             logic [BYTE_W-1:0] cb, logic rd_fail, logic rs_fail);
    frame_t f;
    f.flow_hi = hi;
    f.flow_lo = lo;
    f.crc = cb;
    f.rd_fail = rd_fail;
    f.rs_fail = rs_fail;
    pending_frames.push_back(f);
    frames_queued++;
  endtask

  task automatic queue_good(logic [RAW_W-1:0] raw, logic rs_fail);
    queue_frame(raw[15:8], raw[7:0], check_byte(raw), 1'b0, rs_fail);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (frames_taken != frames_queued || expected_readings.size() != 0);
  endtask

  task automatic program_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_FLOW_OFFSET: offset_cfg = data;
      REG_FLOW_SCALE:  scale_cfg = data;
      REG_CRC_POLY:    poly_cfg = data[BYTE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [RAW_W-1:0] offset, logic [DIVISOR_W-1:0] scale,
                           logic [BYTE_W-1:0] poly, int count);
    logic [RAW_W-1:0] raw;
    int               pick;
    wait_drained();
    program_register(REG_FLOW_OFFSET, offset);
    program_register(REG_FLOW_SCALE, scale);
    program_register(REG_CRC_POLY, {8'h00, poly});
    @(negedge clk);
    cfg_valid <= 1'b0;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      raw = RAW_W'($urandom_range(0, 65535));
      case ($urandom_range(0, 11))
        0: raw = '0;
        1: raw = '1;
        2: raw = offset_cfg;
        3: raw = RAW_W'(offset_cfg + $urandom_range(0, 2) - 1);
        default: ;
      endcase
      if (pick < 70) begin
        queue_good(raw, 1'($urandom_range(0, 1)));
      end else if (pick < 82) begin
        queue_frame(raw[15:8], raw[7:0], BYTE_W'(check_byte(raw) ^ $urandom_range(1, 255)),
                    1'b0, 1'($urandom_range(0, 1)));
      end else begin
        queue_frame(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                    BYTE_W'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Sender: bursts of frames separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_acc) begin
      // hold until transfer
    end else if (idle_left != 0) begin
      in_valid <= 1'b0;
      idle_left--;
    end else if (pending_frames.size() != 0) begin
      send_frame = pending_frames.pop_front();
      in_flow_high_byte <= send_frame.flow_hi;
      in_flow_low_byte <= send_frame.flow_lo;
      in_crc_byte <= send_frame.crc;
      in_read_failed <= send_frame.rd_fail;
      in_resend_failed <= send_frame.rs_fail;
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        case ($urandom_range(0, 5))
          0, 1: idle_left = 0;
          2:    idle_left = $urandom_range(20, 60);
          default: idle_left = $urandom_range(1, 12);
        endcase
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: switch stall pattern every so often
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_left--;
    end
    case (rx_pattern)
      RX_STEADY: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_left % 8) < 5;
    endcase
  end

  // Monitor: check results first, then record the accepted frame
  always @(posedge clk) begin
    in_acc <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("unexpected result: flow %0d upd %b crc_err %b err %b",
                     out_flow_value, out_sample_updated, out_crc_mismatch,
                     out_sensor_error);
          end
        end else begin
          want = expected_readings.pop_front();
          if (out_flow_value !== want.flow || out_sample_updated !== want.updated ||
              out_crc_mismatch !== want.mismatch || out_sensor_error !== want.error) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("mismatch: exp flow %0d upd %b crc_err %b err %b",
                       want.flow, want.updated, want.mismatch, want.error);
              $display("          got flow %0d upd %b crc_err %b err %b",
                       out_flow_value, out_sample_updated, out_crc_mismatch,
                       out_sensor_error);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_readings.push_back(predict_reading('{in_flow_high_byte,
            in_flow_low_byte, in_crc_byte, in_read_failed, in_resend_failed}));
        frames_taken++;
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under reset settings
    queue_good(16'h0000, 1'b0);
    queue_good(16'hFFFF, 1'b0);
    queue_good(OFFSET_RST, 1'b0);
    queue_good(OFFSET_RST + 16'd1, 1'b0);
    queue_good(OFFSET_RST - 16'd1, 1'b0);
    queue_frame(8'h12, 8'h34, check_byte(16'h1234) ^ 8'h80, 1'b0, 1'b0);
    queue_frame(8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
    queue_frame(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
    queue_frame(8'hAB, 8'hCD, check_byte(16'hABCD) ^ 8'h01, 1'b0, 1'b0);
    queue_frame(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    queue_good(16'h55AA, 1'b0);
    queue_frame(8'h5A, 8'hA5, 8'h3C, 1'b1, 1'b0);
    queue_frame(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    queue_good(16'hAA55, 1'b1);
    queue_frame(8'h00, 8'h00, 8'hFF, 1'b0, 1'b1);
    queue_frame(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    queue_frame(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    queue_good(16'h8000, 1'b0);
    queue_good(16'h7FFF, 1'b0);

    // Extremes of every register, then random settings, then the reset settings
    run_phase(16'd0, 16'd1, 8'h31, 75);
    run_phase(16'hFFFF, 16'd1, 8'h07, 75);
    run_phase(16'hFFFF, 16'hFFFF, 8'hFF, 75);
    run_phase(16'd0, 16'hFFFF, 8'h00, 75);
    run_phase(16'h8000, 16'd0, 8'h31, 75);
    run_phase(RAW_W'($urandom_range(0, 65535)), DIVISOR_W'($urandom_range(1, 300)),
              BYTE_W'($urandom_range(0, 255)), 75);
    run_phase(RAW_W'($urandom_range(0, 65535)), DIVISOR_W'($urandom_range(1, 65535)),
              BYTE_W'($urandom_range(0, 255)), 75);
    run_phase(OFFSET_RST, SCALE_RST, POLY_RST, 75);

    wait_drained();
    repeat (48) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/fsfd_pkg.sv
src/fsfd_divider.sv
src/flow_sensor_frame_decoder_unit.sv
tb/testbench.sv
